@@ sv/cad_pkg.sv @@
// Package for the circular-array deque: field widths, command and status
// codes, and the sequencer state type. No dependencies.
`default_nettype none

package cad_pkg;

    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_POP_WAIT,
        SEQ_DUMP
    } seq_state_t;

endpackage : cad_pkg

`default_nettype wire

@@ sv/circular_array_deque.sv @@
// A push result is in the output register in the cycle after its transfer;
// a pop result passes the memory read register and then the output register;
// a dump of N entries passes each entry, front first, through the same two
// registers. One item at a time: a new command is taken only when the
// sequencer is idle. Reset (aresetn, synchronous, active low) empties the
// deque; the entry memory itself is not cleared.
`default_nettype none

module circular_array_deque
    import cad_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // command channel
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [CMD_W-1:0]           s_cmd,
    input  wire logic signed [DATA_W-1:0]   s_value,
    // result channel
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [DATA_W-1:0]        m_data,
    output logic [STATUS_W-1:0]             m_status,
    output logic                            m_last,
    output logic [OCC_W-1:0]                m_occupancy
);

    // Index and count widths follow from the depth. The count must hold
    // DEPTH itself, so it is one bit wider than an index when DEPTH is a
    // power of two greater than one.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Circular index arithmetic: both ends wrap at the store boundary.
    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - IDX_W'(1);
    endfunction

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    seq_state_t                 state_reg, state_next;
    logic [IDX_W-1:0]           front_reg, front_next;
    logic [IDX_W-1:0]           rear_reg, rear_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           dump_idx_reg, dump_idx_next;
    logic [CNT_W-1:0]           dump_left_reg, dump_left_next;

    // Output register, which holds each result until its transfer; the
    // sequencer does not pass on a new result while it is blocked.
    logic                       m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0]   m_data_reg, m_data_next;
    logic [STATUS_W-1:0]        m_status_reg, m_status_next;
    logic                       m_last_reg, m_last_next;
    logic [OCC_W-1:0]           m_occ_reg, m_occ_next;

    // Entry memory: one write port, one read port, registered read data.
    logic signed [DATA_W-1:0]   mem [DEPTH];
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic signed [DATA_W-1:0]   mem_wdata;
    logic                       mem_re;
    logic [IDX_W-1:0]           mem_raddr;
    logic signed [DATA_W-1:0]   rd_data_reg;

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    logic out_free;
    logic s_fire;
    logic is_empty;
    logic is_full;

    // The output register can take a new result when it is empty or its
    // current result transfers in this cycle.
    assign out_free = !m_valid_reg || m_ready;
    // A new command is taken only when the sequencer is idle and a result
    // produced by the command has somewhere to go.
    assign s_ready  = (state_reg == SEQ_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_FULL);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (s_fire) begin
                    case (s_cmd)
                        CMD_POP_FRONT, CMD_POP_REAR: begin
                            if (!is_empty) begin
                                state_next = SEQ_POP_WAIT;
                            end
                        end
                        CMD_DUMP: begin
                            if (!is_empty) begin
                                state_next = SEQ_DUMP;
                            end
                        end
                        default: begin
                            state_next = SEQ_IDLE;
                        end
                    endcase
                end
            end
            SEQ_POP_WAIT: begin
                if (out_free) begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_DUMP: begin
                if (out_free && (dump_left_reg == CNT_W'(1))) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath, memory controls and result generation
    // ------------------------------------------------------------------
    always_comb begin
        front_next     = front_reg;
        rear_next      = rear_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        dump_left_next = dump_left_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = s_value;
        mem_re    = 1'b0;
        mem_raddr = front_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        m_occ_next    = m_occ_reg;

        case (state_reg)
            SEQ_IDLE: begin
                if (s_fire) begin
                    case (s_cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                            m_last_next  = 1'b1;
                            if (is_full) begin
                                m_status_next = STAT_FULL;
                                m_occ_next    = OCC_W'(count_reg);
                            end else begin
                                m_status_next = STAT_OK;
                                mem_we        = 1'b1;
                                if (is_empty) begin
                                    // The first entry always lands at index zero.
                                    front_next = '0;
                                    rear_next  = '0;
                                    mem_waddr  = '0;
                                end else if (s_cmd == CMD_PUSH_FRONT) begin
                                    front_next = idx_prev(front_reg);
                                    mem_waddr  = idx_prev(front_reg);
                                end else begin
                                    rear_next = idx_next(rear_reg);
                                    mem_waddr = idx_next(rear_reg);
                                end
                                count_next = count_reg + CNT_W'(1);
                                m_occ_next = OCC_W'(count_reg + CNT_W'(1));
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_REAR: begin
                            if (is_empty) begin
                                m_valid_next  = 1'b1;
                                m_data_next   = '0;
                                m_status_next = STAT_EMPTY;
                                m_last_next   = 1'b1;
                                m_occ_next    = OCC_W'(count_reg);
                            end else begin
                                // The pointers move now; the removed word
                                // arrives from the memory in the next cycle.
                                mem_re = 1'b1;
                                if (s_cmd == CMD_POP_FRONT) begin
                                    mem_raddr  = front_reg;
                                    front_next = idx_next(front_reg);
                                end else begin
                                    mem_raddr = rear_reg;
                                    rear_next = idx_prev(rear_reg);
                                end
                                count_next = count_reg - CNT_W'(1);
                                if (count_reg == CNT_W'(1)) begin
                                    front_next = '0;
                                    rear_next  = '0;
                                end
                            end
                        end
                        CMD_DUMP: begin
                            if (is_empty) begin
                                m_valid_next  = 1'b1;
                                m_data_next   = '0;
                                m_status_next = STAT_EMPTY;
                                m_last_next   = 1'b1;
                                m_occ_next    = OCC_W'(count_reg);
                            end else begin
                                mem_re         = 1'b1;
                                mem_raddr      = front_reg;
                                dump_idx_next  = idx_next(front_reg);
                                dump_left_next = count_reg;
                            end
                        end
                        default: begin
                            // Unused command codes are consumed without a result.
                            m_valid_next = m_valid_reg && !m_ready;
                        end
                    endcase
                end
            end
            SEQ_POP_WAIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = rd_data_reg;
                    m_status_next = STAT_OK;
                    m_last_next   = 1'b1;
                    m_occ_next    = OCC_W'(count_reg);
                end
            end
            SEQ_DUMP: begin
                // Read data stays put while the output register is blocked,
                // since no new read is issued until the entry moves on.
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = rd_data_reg;
                    m_status_next = STAT_OK;
                    m_last_next   = (dump_left_reg == CNT_W'(1));
                    m_occ_next    = OCC_W'(count_reg);
                    if (dump_left_reg != CNT_W'(1)) begin
                        mem_re         = 1'b1;
                        mem_raddr      = dump_idx_reg;
                        dump_idx_next  = idx_next(dump_idx_reg);
                        dump_left_next = dump_left_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SEQ_IDLE;
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            dump_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            dump_left_reg <= dump_left_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        m_occ_reg    <= m_occ_next;
    end

    // Entry memory. A read and a write never hit the same cycle, because
    // only one command is in flight and pushes never read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign m_status    = m_status_reg;
    assign m_last      = m_last_reg;
    assign m_occupancy = m_occ_reg;

endmodule : circular_array_deque

`default_nettype wire

@@ sv/cad_checker.sv @@
// Port-level checker for the circular-array deque, bound to the top level.
// Depends on cad_pkg for the status codes and field widths.
`default_nettype none

module cad_checker
    import cad_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic signed [DATA_W-1:0]  m_data,
    input wire logic [STATUS_W-1:0]       m_status,
    input wire logic                      m_last,
    input wire logic [OCC_W-1:0]          m_occupancy
);

    // A full report only comes with a deque that holds DEPTH entries.
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_FULL) |->
            (m_data == '0 && m_last && m_occupancy == OCC_W'(DEPTH)))
        else $error("full result with wrong data, last or occupancy");

    // An empty report means nothing is held and the command is finished.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_EMPTY) |->
            (m_data == '0 && m_last && m_occupancy == '0))
        else $error("empty result with wrong data, last or occupancy");

    // No new command is taken while a dump is still listing entries.
    a_no_accept_mid_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> !(s_valid && s_ready))
        else $error("command taken in the middle of a dump");

    // The held count never exceeds the store.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy beyond depth");

    // A stalled result holds still.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_data) && $stable(m_status) && $stable(m_last)
             && $stable(m_occupancy)))
        else $error("stalled result changed");

endmodule : cad_checker

bind circular_array_deque cad_checker #(.DEPTH(DEPTH)) u_cad_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data),
    .m_status    (m_status),
    .m_last      (m_last),
    .m_occupancy (m_occupancy)
);

`default_nettype wire
